@@ hdl/sac_pkg.sv @@
`timescale 1ns / 1ps
package sac_pkg;

  localparam int DEF_NUM_CLASSES    = 10;
  localparam int DEF_SLAB_BYTES     = 8192;
  localparam int DEF_MIN_SLOT_SHIFT = 3;
  localparam int ADDR_BITS          = 48;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 64;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((48'd1 << ADDR_BITS) - 48'd1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 3'd4;

  localparam logic [CFG_AW-1:0] REG_HEAP_BASE = 3'd0;

  function automatic logic [4:0] ceil_log2_16(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] m;
    logic [4:0]        n;
    m = v - 16'd1;
    n = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ hdl/sac_in_if.sv @@
`timescale 1ns / 1ps
interface sac_in_if import sac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, func, req_size, free_address, input ready);
  modport sink   (input valid, func, req_size, free_address, output ready);
endinterface

@@ hdl/sac_out_if.sv @@
`timescale 1ns / 1ps
interface sac_out_if import sac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   alloc_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, alloc_address, status, input ready);
  modport sink   (input valid, alloc_address, status, output ready);
endinterface

@@ hdl/slab_size_class_allocator_top.sv @@
// A request is looked up in S_EVAL, where no new one is taken; its result is
// loaded in S_FIN once the output register is free. The link memory read of a
// stack pop lands in the cycle after the lookup; the stack top is updated from it.
// Reset (synchronous, rst_n low): stacks empty, fresh marks zero, heap_base zero.
// The link memory is not cleared; an entry is only read after it has been written.
`timescale 1ns / 1ps
module slab_size_class_allocator_top import sac_pkg::*; #(
  parameter int NUM_CLASSES    = DEF_NUM_CLASSES,
  parameter int SLAB_BYTES     = DEF_SLAB_BYTES,
  parameter int MIN_SLOT_SHIFT = DEF_MIN_SLOT_SHIFT
) (
  input  logic              clk,
  input  logic              rst_n,
  sac_in_if.sink            in_if,
  sac_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int SLAB_SHIFT = $clog2(SLAB_BYTES);
  localparam int MAX_SLOTS  = SLAB_BYTES >> MIN_SLOT_SHIFT;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int LMEM_DEPTH = 2 * MAX_SLOTS;
  localparam int LADDR_W    = $clog2(LMEM_DEPTH);
  localparam int HEAP_SPAN  = NUM_CLASSES * SLAB_BYTES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
  } link_t;

  logic [1:0]          state_r;
  logic                out_vld_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   base_r;

  logic                func_r;
  logic [SIZE_W-1:0]   size_r;
  logic [ADDR_W-1:0]   off_r;
  logic                brw_r;
  logic [CLS_W-1:0]    cls_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [STATUS_W-1:0] status_r;
  logic                pop_r;

  link_t               top_r   [NUM_CLASSES];
  logic [SLOT_W:0]     untch_r [NUM_CLASSES];

  link_t               lnk_mem [LMEM_DEPTH];
  link_t               lnk_rdata_r;

  logic                out_free;
  logic                in_acc;
  logic                eval;
  logic [SIZE_W-1:0]   size_c;
  logic [4:0]          craw_c;
  logic [CLS_W-1:0]    cls_c;
  logic [SLOT_W:0]     slots_c;
  logic [4:0]          sh_c;
  logic [SLAB_SHIFT-1:0] in_slab_c;
  logic [SLAB_SHIFT-1:0] slotf_c;
  logic [SLOT_W-1:0]   slot_c;
  logic [STATUS_W-1:0] status_c;
  logic                pop_c;
  logic                push_c;
  logic                fresh_c;
  logic                lnk_re;
  logic                lnk_we;
  logic [LADDR_W:0]    lbase_c;
  logic [LADDR_W-1:0]  lnk_addr;
  logic [4:0]          fin_sh;
  logic [ADDR_W-1:0]   fin_addr;
  logic                cfg_we;

  assign out_free     = !out_vld_r || out_if.ready;
  assign in_if.ready  = (state_r == S_IDLE) || ((state_r == S_FIN) && out_free);
  assign in_acc       = in_if.valid && in_if.ready;
  assign eval         = (state_r == S_EVAL);

  assign out_if.valid         = out_vld_r;
  assign out_if.alloc_address = out_addr_r;
  assign out_if.status        = out_status_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_HEAP_BASE);
  assign prdata = (paddr == REG_HEAP_BASE) ? CFG_DW'(base_r) : '0;

  // class lookup
  always_comb begin
    size_c = (size_r < SIZE_W'(1 << MIN_SLOT_SHIFT)) ? SIZE_W'(1 << MIN_SLOT_SHIFT)
                                                     : size_r;
    craw_c = ceil_log2_16(size_c) - 5'(MIN_SLOT_SHIFT);
    if (func_r == FUNC_ALLOC) begin
      cls_c = craw_c[CLS_W-1:0];
    end else begin
      cls_c = off_r[SLAB_SHIFT +: CLS_W];
    end
    slots_c   = (SLOT_W+1)'(MAX_SLOTS) >> cls_c;
    sh_c      = 5'(MIN_SLOT_SHIFT) + 5'(cls_c);
    in_slab_c = off_r[SLAB_SHIFT-1:0];
    slotf_c   = in_slab_c >> sh_c;
  end

  always_comb begin
    status_c = ST_OK;
    slot_c   = '0;
    pop_c    = 1'b0;
    push_c   = 1'b0;
    fresh_c  = 1'b0;
    if (func_r == FUNC_ALLOC) begin
      if (craw_c >= 5'(NUM_CLASSES)) begin
        status_c = ST_OVERSIZE;
      end else if (top_r[cls_c].vld) begin
        slot_c = top_r[cls_c].idx;
        pop_c  = 1'b1;
      end else if (untch_r[cls_c] < slots_c) begin
        slot_c  = untch_r[cls_c][SLOT_W-1:0];
        fresh_c = 1'b1;
      end else begin
        status_c = ST_EXHAUSTED;
      end
    end else begin
      if (brw_r || (off_r >= ADDR_W'(HEAP_SPAN))) begin
        status_c = ST_OUTSIDE;
      end else if ((in_slab_c & ~({SLAB_SHIFT{1'b1}} << sh_c)) != '0) begin
        status_c = ST_MISALIGN;
      end else if ((SLAB_SHIFT+1)'(slotf_c) >= (SLAB_SHIFT+1)'(slots_c)) begin
        status_c = ST_MISALIGN;
      end else begin
        slot_c = slotf_c[SLOT_W-1:0];
        push_c = 1'b1;
      end
    end
  end

  assign lnk_re   = eval && pop_c;
  assign lnk_we   = eval && push_c;
  assign lbase_c  = (LADDR_W+1)'(LMEM_DEPTH) - ((LADDR_W+1)'(LMEM_DEPTH) >> cls_c);
  assign lnk_addr = LADDR_W'(lbase_c + (LADDR_W+1)'(slot_c));

  always_ff @(posedge clk) begin
    if (lnk_we) lnk_mem[lnk_addr] <= top_r[cls_c];
    if (lnk_re) lnk_rdata_r <= lnk_mem[lnk_addr];
  end

  // granted address
  always_comb begin
    fin_sh   = 5'(MIN_SLOT_SHIFT) + 5'(cls_r);
    fin_addr = (base_r + (ADDR_W'(cls_r) << SLAB_SHIFT) + (ADDR_W'(slot_r) << fin_sh))
               & ADDR_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      base_r    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        top_r[i]   <= '0;
        untch_r[i] <= '0;
      end
    end else begin
      if (cfg_we) base_r <= pwdata[ADDR_W-1:0];
      out_vld_r <= ((state_r == S_FIN) && out_free) || (out_vld_r && !out_if.ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (push_c) top_r[cls_c] <= '{vld: 1'b1, idx: slot_c};
          if (fresh_c) untch_r[cls_c] <= untch_r[cls_c] + 1'b1;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (pop_r) top_r[cls_r] <= lnk_rdata_r;
            state_r   <= in_acc ? S_EVAL : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r          <= in_if.func;
      size_r          <= in_if.req_size;
      {brw_r, off_r}  <= {1'b0, in_if.free_address} - {1'b0, base_r};
    end
    if (eval) begin
      cls_r    <= cls_c;
      slot_r   <= slot_c;
      status_r <= status_c;
      pop_r    <= pop_c;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_status_r <= status_r;
      out_addr_r   <= ((func_r == FUNC_ALLOC) && (status_r == ST_OK)) ? fin_addr : '0;
    end
  end

  a_no_accept_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> !in_if.ready)
    else $error("input accepted during lookup");

  a_pop_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    lnk_re |=> ((state_r == S_FIN) && pop_r))
    else $error("pop read not followed by stack top update");

  a_push_sets_top: assert property (@(posedge clk) disable iff (!rst_n)
    lnk_we |=> top_r[$past(cls_c)].vld)
    else $error("push left stack empty");

  a_one_mem_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(lnk_we && lnk_re))
    else $error("link memory read and write in one cycle");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != ST_OK)) |-> (out_if.alloc_address == '0))
    else $error("error result carries an address");

endmodule
